// File: sv/oaat_pkg.sv
// Package for the open-address attribute table: codes, slot states,
// write-control struct and default sizes. No dependencies.
`default_nettype none
package oaat_pkg;

  // Default sizes for the top-level parameters
  localparam int DEF_MAX_BUCKETS  = 1024;
  localparam int DEF_INIT_BUCKETS = 8;
  localparam int DEF_HANDLE_WIDTH = 32;

  // Fixed port field widths
  localparam int HANDLE_PORT_W = 32;
  localparam int BUCKET_PORT_W = 10;

  typedef enum logic [1:0] {
    OP_FIND_INSERT = 2'd0,
    OP_FIND        = 2'd1,
    OP_REMOVE      = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RS_FOUND    = 2'd0,
    RS_INSERTED = 2'd1,
    RS_MISSING  = 2'd2,
    RS_FULL     = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

  // Write strobes towards the slot store
  typedef struct packed {
    logic st_we;    // status array
    logic data_we;  // key, value and hash arrays
  } wr_ctl_t;

  typedef enum logic [3:0] {
    S_INIT,   // clear status of the first bank after reset
    S_IDLE,
    S_PRD,    // probe read
    S_PCHK,   // probe check
    S_RMRD,   // remove read
    S_RMCHK,  // remove check
    S_CRD,    // rehash: count live entries
    S_CCHK,
    S_CLR,    // rehash: clear spare bank
    S_MRD,    // rehash: read old entry
    S_MCHK,
    S_SRD,    // rehash: probe spare bank
    S_SCHK,
    S_FIN,    // rehash: swap banks
    S_DONE    // hand result to output register
  } state_t;

endpackage
`default_nettype wire

// File: sv/oaat_req_if.sv
// Request channel of the attribute table: valid/ready and the input fields.
// Depends on nothing.
`default_nettype none
interface oaat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] key;
  logic [31:0] key_hash;
  logic [31:0] new_value;
  logic [9:0]  bucket_index;

  modport source (output valid, op, key, key_hash, new_value, bucket_index, input ready);
  modport sink   (input valid, op, key, key_hash, new_value, bucket_index, output ready);
endinterface
`default_nettype wire

// File: sv/oaat_rsp_if.sv
// Response channel of the attribute table: valid/ready and the result fields.
// Depends on nothing.
`default_nettype none
interface oaat_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value;
  logic [9:0]  bucket;
  logic        grew;

  modport source (output valid, status, value, bucket, grew, input ready);
  modport sink   (input valid, status, value, bucket, grew, output ready);
endinterface
`default_nettype wire

// File: sv/oaat_mem.sv
// Two-bank slot store: status, key, value and stored hash per bucket.
// One write port, one registered read port. Depends on oaat_pkg.
`default_nettype none
module oaat_mem import oaat_pkg::*; #(
  parameter int AW = 10,
  parameter int HW = 32
) (
  input  wire logic          clk,
  input  wire logic [AW:0]   rd_addr,
  output slot_st_t           rd_status,
  output logic [HW-1:0]      rd_key,
  output logic [HW-1:0]      rd_value,
  output logic [AW-1:0]      rd_hash,
  input  wire logic [AW:0]   wr_addr,
  input  wire wr_ctl_t       wr,
  input  wire slot_st_t      wr_status,
  input  wire logic [HW-1:0] wr_key,
  input  wire logic [HW-1:0] wr_value,
  input  wire logic [AW-1:0] wr_hash
);

  localparam int DEPTH = 2 << AW;

  slot_st_t          mem_status [DEPTH];
  logic [HW-1:0]     mem_key    [DEPTH];
  logic [HW-1:0]     mem_value  [DEPTH];
  logic [AW-1:0]     mem_hash   [DEPTH];

  // Writes
  always_ff @(posedge clk) begin
    if (wr.st_we) begin
      mem_status[wr_addr] <= wr_status;
    end
    if (wr.data_we) begin
      mem_key[wr_addr]   <= wr_key;
      mem_value[wr_addr] <= wr_value;
      mem_hash[wr_addr]  <= wr_hash;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rd_status <= mem_status[rd_addr];
    rd_key    <= mem_key[rd_addr];
    rd_value  <= mem_value[rd_addr];
    rd_hash   <= mem_hash[rd_addr];
  end

endmodule
`default_nettype wire

// File: sv/open_address_attribute_table.sv
// Open-addressed attribute table with triangular probing. One transaction at
// a time: after reset the block clears the status of its first INIT_BUCKETS
// buckets before it takes a request. A lookup reads and then checks each
// bucket probed through the single registered read port of the slot store;
// a remove reads and checks the indexed bucket. An insert that uses up the
// last free slot rehashes into the spare bank: it counts the live entries
// of the old bank, clears the new buckets of the spare bank, moves each live
// entry into it by probing, then swaps banks. A result waits in an output
// register until it is taken.
// Depends on oaat_pkg, oaat_req_if, oaat_rsp_if and oaat_mem.
`default_nettype none
module open_address_attribute_table import oaat_pkg::*; #(
  parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
  parameter int INIT_BUCKETS = DEF_INIT_BUCKETS,
  parameter int HANDLE_WIDTH = DEF_HANDLE_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst,
  oaat_req_if.sink  req,
  oaat_rsp_if.source rsp
);

  localparam int AW       = $clog2(MAX_BUCKETS);
  localparam int CW       = AW + 1;
  localparam int HW       = (HANDLE_WIDTH > HANDLE_PORT_W) ? HANDLE_PORT_W : HANDLE_WIDTH;
  localparam int LW       = $clog2(AW + 1) + 1;
  localparam int INIT_LG  = $clog2(INIT_BUCKETS);
  localparam int INIT_CAP = (2 * INIT_BUCKETS) / 3;
  localparam int WW       = (CW > BUCKET_PORT_W) ? CW : BUCKET_PORT_W;

  state_t state, state_next;

  // Table state
  logic          bank;
  logic [LW-1:0] lg, lg_new;
  logic [AW-1:0] cap;
  logic [AW-1:0] remaining;

  // Request registers
  op_t           op;
  logic [HW-1:0] key;
  logic [AW-1:0] hash;
  logic [HW-1:0] nval;
  logic [BUCKET_PORT_W-1:0] bidx;

  // Probe and rehash working registers
  logic [AW-1:0] b;
  logic [CW-1:0] n;
  logic          tomb_seen;
  logic [AW-1:0] tomb;
  logic [CW-1:0] i;
  logic [CW-1:0] live;
  logic [AW-1:0] track;
  logic [AW-1:0] where_b;
  logic [HW-1:0] mv_key;
  logic [HW-1:0] mv_value;
  logic [AW-1:0] mv_hash;

  // Result
  res_t          res_status;
  logic [HW-1:0] res_value;
  logic [AW-1:0] res_bucket;
  logic          res_grew;

  // Output register
  logic          out_valid;
  res_t          out_status;
  logic [HW-1:0] out_value;
  logic [AW-1:0] out_bucket;
  logic          out_grew;

  // Store ports
  logic [AW:0]   rd_addr, wr_addr;
  wr_ctl_t       wr;
  slot_st_t      wr_status;
  logic [HW-1:0] wr_key, wr_value;
  logic [AW-1:0] wr_hash;
  slot_st_t      rd_status;
  logic [HW-1:0] rd_key, rd_value;
  logic [AW-1:0] rd_hash;

  oaat_mem #(.AW(AW), .HW(HW)) u_mem (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_status (rd_status),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .rd_hash   (rd_hash),
    .wr_addr   (wr_addr),
    .wr        (wr),
    .wr_status (wr_status),
    .wr_key    (wr_key),
    .wr_value  (wr_value),
    .wr_hash   (wr_hash)
  );

  // Sizes and probe steps
  logic [CW-1:0] nb, nb_new;
  logic [AW-1:0] mask, mask_new;
  logic [AW-1:0] b_step, b_step_new;
  logic [AW-1:0] in_b;
  logic          in_bidx_ok;
  assign nb         = CW'(1) << lg;
  assign nb_new     = CW'(1) << lg_new;
  assign mask       = AW'(nb - CW'(1));
  assign mask_new   = AW'(nb_new - CW'(1));
  assign b_step     = AW'(CW'(b) + n + CW'(1)) & mask;
  assign b_step_new = AW'(CW'(b) + n + CW'(1)) & mask_new;
  assign in_b       = AW'(req.key_hash) & mask;
  assign in_bidx_ok = WW'(req.bucket_index) < WW'(nb);

  // Probe decisions
  logic          p_hit, p_empty, p_tomb, p_last, p_tomb_any;
  logic [AW-1:0] p_tomb_at;
  logic          ins_tomb, ins_empty, p_miss;
  logic          last_i, last_clr, live_now;
  logic [CW-1:0] live_final;
  logic          doubles;
  always_comb begin
    p_hit      = (rd_status == ST_LIVE) && (rd_key == key);
    p_empty    = (rd_status == ST_EMPTY);
    p_tomb     = (rd_status == ST_TOMB);
    p_last     = (n + CW'(1)) == nb;
    p_tomb_any = tomb_seen || p_tomb;
    p_tomb_at  = p_tomb ? b : tomb;
    p_miss     = !p_hit && (p_empty || p_last);
    ins_tomb   = p_miss && (op == OP_FIND_INSERT) && p_tomb_any;
    ins_empty  = p_miss && (op == OP_FIND_INSERT) && !p_tomb_any && p_empty &&
                 (remaining != '0);
    last_i     = i == (nb - CW'(1));
    last_clr   = i == (nb_new - CW'(1));
    live_now   = rd_status == ST_LIVE;
    live_final = live + CW'(live_now);
    doubles    = (live_final > (nb >> 1)) && (nb < CW'(MAX_BUCKETS));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT:  if (i == CW'(INIT_BUCKETS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (req.valid) begin
          case (op_t'(req.op))
            OP_FIND_INSERT, OP_FIND: state_next = S_PRD;
            OP_REMOVE: state_next = in_bidx_ok ? S_RMRD : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_PRD:   state_next = S_PCHK;
      S_PCHK: begin
        if (p_hit || p_miss) begin
          state_next = (ins_empty && remaining == AW'(1)) ? S_CRD : S_DONE;
        end else begin
          state_next = S_PRD;
        end
      end
      S_RMRD:  state_next = S_RMCHK;
      S_RMCHK: state_next = S_DONE;
      S_CRD:   state_next = S_CCHK;
      S_CCHK:  state_next = last_i ? S_CLR : S_CRD;
      S_CLR:   if (last_clr) state_next = S_MRD;
      S_MRD:   state_next = S_MCHK;
      S_MCHK: begin
        if (live_now)    state_next = S_SRD;
        else if (last_i) state_next = S_FIN;
        else             state_next = S_MRD;
      end
      S_SRD:   state_next = S_SCHK;
      S_SCHK: begin
        if (p_empty || n == nb_new) state_next = last_i ? S_FIN : S_MRD;
        else                        state_next = S_SRD;
      end
      S_FIN:   state_next = S_DONE;
      S_DONE:  if (!out_valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Store controls
  always_comb begin
    rd_addr   = {bank, b};
    wr_addr   = {bank, b};
    wr        = '0;
    wr_status = ST_EMPTY;
    wr_key    = key;
    wr_value  = nval;
    wr_hash   = hash;
    case (state)
      S_INIT: begin
        wr_addr  = {1'b0, i[AW-1:0]};
        wr.st_we = 1'b1;
      end
      S_RMRD:  rd_addr = {bank, AW'(bidx)};
      S_PCHK: begin
        wr_addr   = ins_tomb ? {bank, p_tomb_at} : {bank, b};
        wr_status = ST_LIVE;
        wr.st_we  = ins_tomb || ins_empty;
        wr.data_we = ins_tomb || ins_empty;
      end
      S_RMCHK: begin
        wr_addr   = {bank, AW'(bidx)};
        wr_status = ST_TOMB;
        wr.st_we  = live_now;
      end
      S_CRD, S_MRD: rd_addr = {bank, i[AW-1:0]};
      S_CLR: begin
        wr_addr  = {~bank, i[AW-1:0]};
        wr.st_we = 1'b1;
      end
      S_SRD:  rd_addr = {~bank, b};
      S_SCHK: begin
        wr_addr    = {~bank, b};
        wr_status  = ST_LIVE;
        wr_key     = mv_key;
        wr_value   = mv_value;
        wr_hash    = mv_hash;
        wr.st_we   = p_empty || n == nb_new;
        wr.data_we = p_empty || n == nb_new;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      bank      <= 1'b0;
      lg        <= LW'(INIT_LG);
      cap       <= AW'(INIT_CAP);
      remaining <= AW'(INIT_CAP);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PCHK && ins_empty) remaining <= remaining - AW'(1);
      if (state == S_FIN) begin
        bank <= ~bank;
        lg   <= lg_new;
        if (lg_new != lg) begin
          cap <= AW'({cap, ~lg[0]});
          remaining <= (CW'({cap, ~lg[0]}) > live) ?
                       AW'(CW'({cap, ~lg[0]}) - live) : '0;
        end else begin
          remaining <= (CW'(cap) > live) ? AW'(CW'(cap) - live) : '0;
        end
      end
      if (state == S_DONE && (!out_valid || rsp.ready)) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_INIT: i <= rst ? '0 : i + CW'(1);
      S_IDLE: begin
        op         <= op_t'(req.op);
        key        <= req.key[HW-1:0];
        hash       <= AW'(req.key_hash);
        nval       <= req.new_value[HW-1:0];
        bidx       <= req.bucket_index;
        b          <= in_b;
        n          <= '0;
        tomb_seen  <= 1'b0;
        res_status <= RS_MISSING;
        res_value  <= '0;
        res_bucket <= (op_t'(req.op) == OP_REMOVE) ? AW'(req.bucket_index) : '0;
        res_grew   <= 1'b0;
      end
      S_PCHK: begin
        if (p_tomb) begin
          tomb_seen <= 1'b1;
          tomb      <= b;
        end
        b <= b_step;
        n <= n + CW'(1);
        if (p_hit) begin
          res_status <= RS_FOUND;
          res_value  <= rd_value;
          res_bucket <= b;
        end else if (ins_tomb) begin
          res_status <= RS_INSERTED;
          res_value  <= nval;
          res_bucket <= p_tomb_at;
        end else if (ins_empty) begin
          res_status <= RS_INSERTED;
          res_value  <= nval;
          res_bucket <= b;
          track      <= b;
          i          <= '0;
          live       <= '0;
        end else if (p_miss && op == OP_FIND_INSERT) begin
          res_status <= RS_FULL;
        end
      end
      S_RMCHK: if (live_now) res_status <= RS_FOUND;
      S_CCHK: begin
        live <= live_final;
        if (last_i) begin
          i      <= '0;
          lg_new <= doubles ? lg + LW'(1) : lg;
        end else begin
          i <= i + CW'(1);
        end
      end
      S_CLR: i <= last_clr ? '0 : i + CW'(1);
      S_MCHK: begin
        mv_key   <= rd_key;
        mv_value <= rd_value;
        mv_hash  <= rd_hash;
        b        <= rd_hash & mask_new;
        n        <= '0;
        if (!live_now && !last_i) i <= i + CW'(1);
      end
      S_SCHK: begin
        if (p_empty || n == nb_new) begin
          if (i[AW-1:0] == track) where_b <= b;
          if (!last_i) i <= i + CW'(1);
        end else begin
          b <= b_step_new;
          n <= n + CW'(1);
        end
      end
      S_FIN: begin
        res_bucket <= where_b;
        res_grew   <= 1'b1;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_status <= res_status;
          out_value  <= res_value;
          out_bucket <= res_bucket;
          out_grew   <= res_grew;
        end
      end
      default: ;
    endcase
  end

  // Ports
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.value  = HANDLE_PORT_W'(out_value);
  assign rsp.bucket = BUCKET_PORT_W'(out_bucket);
  assign rsp.grew   = out_grew;

endmodule
`default_nettype wire
